// File: hdl/tmp_pkg.sv
// Shared types, constants and helper functions of the trapezoidal motion profile.
`timescale 1ns / 1ps
package tmp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;   // power of two, the pointers wrap on their own
    localparam int OUT_DEPTH     = 4;   // power of two
    localparam int VP_W          = 56;  // peak speed width, enough for the smallest FRAC_BITS
    localparam int VP_HALF       = VP_W / 2;
    localparam int DIV_NUM_W     = 96;

    localparam logic [60:0] TERM_CAP = 61'h1 << 60;

    localparam logic [1:0] REG_START_POS = 2'd0;
    localparam logic [1:0] REG_END_POS   = 2'd1;
    localparam logic [1:0] REG_VEL_LIM   = 2'd2;
    localparam logic [1:0] REG_ACC_LIM   = 2'd3;

    typedef enum logic [2:0] {
        PH_BEFORE = 3'd0,
        PH_END    = 3'd1,
        PH_ACC    = 3'd2,
        PH_CRU    = 3'd3,
        PH_DEC    = 3'd4
    } t_phase;

    typedef struct packed {
        logic               en;
        logic               neg;
        logic [63:0]        t1;
        logic [63:0]        t2;
        logic [63:0]        dur;
        logic [VP_W-1:0]    vp;
        logic [60:0]        dist1;
        logic [61:0]        dist12;
        logic signed [31:0] start_pos;
        logic signed [31:0] end_pos;
        logic [30:0]        acc_lim;
    } t_prof;

    typedef struct packed {
        t_phase      phase;
        logic [30:0] x;
    } t_job;

    function automatic logic [60:0] cap_term(input logic [127:0] v);
        return (v > {67'b0, TERM_CAP}) ? TERM_CAP : v[60:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/trapezoidal_motion_profile.sv
// Top level of the trapezoidal motion profile: registers, profile solver, front and back ends.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  sample    | i_push / o_full           | i_sample_time
//  result    | o_empty / i_pop           | o_position, o_velocity, o_acceleration
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_full is low; a result is registered in the job queue,
// the three-stage multiplier pipeline of the back end and the result queue. That pipeline
// sets the rate, one item a cycle while the result queue has room. After each register write the
// solver runs its shared divide, multiply and square-root unit; o_full, o_cfg_ready report it busy.
// Reset is synchronous and active low and clears the four configuration registers to zero (motion disabled).
// A stalled result side fills the result queue, then the job queue, then raises o_full.
`timescale 1ns / 1ps
module trapezoidal_motion_profile #(
    parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_sample_time,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_acceleration,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    logic signed [31:0] r_start_pos;
    logic signed [31:0] r_end_pos;
    logic [30:0]        r_vel_lim;
    logic [30:0]        r_acc_lim;

    logic           cfg_fire;
    logic           busy;
    tmp_pkg::t_prof prof;
    logic           job_valid;
    logic           job_take;
    tmp_pkg::t_job  job;

    assign o_cfg_ready = !busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_end_pos   <= '0;
            r_vel_lim   <= '0;
            r_acc_lim   <= '0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                tmp_pkg::REG_START_POS: r_start_pos <= i_cfg_data;
                tmp_pkg::REG_END_POS:   r_end_pos   <= i_cfg_data;
                tmp_pkg::REG_VEL_LIM:   r_vel_lim   <= i_cfg_data[30:0];
                tmp_pkg::REG_ACC_LIM:   r_acc_lim   <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    tmp_solver #(.FRAC_BITS(FRAC_BITS)) u_solver (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cfg_fire),
        .i_start_pos (r_start_pos),
        .i_end_pos   (r_end_pos),
        .i_vel_lim   (r_vel_lim),
        .i_acc_lim   (r_acc_lim),
        .o_busy      (busy),
        .o_prof      (prof)
    );

    tmp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_sample_time (i_sample_time),
        .i_hold        (busy),
        .i_prof        (prof),
        .i_job_take    (job_take),
        .o_full        (o_full),
        .o_job_valid   (job_valid),
        .o_job         (job)
    );

    tmp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_prof         (prof),
        .i_job_valid    (job_valid),
        .i_job          (job),
        .o_job_take     (job_take),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration)
    );

endmodule

// File: hdl/tmp_solver.sv
// Sequencer that derives the phase times, peak speed and phase distances from the registers.
`timescale 1ns / 1ps
module tmp_solver #(
    parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_start_pos,
    input  logic signed [31:0] i_end_pos,
    input  logic [30:0]        i_vel_lim,
    input  logic [30:0]        i_acc_lim,
    output logic               o_busy,
    output tmp_pkg::t_prof     o_prof
);
    localparam int NW = tmp_pkg::DIV_NUM_W;

    typedef enum logic [12:0] {
        S_IDLE   = 13'h0001,
        S_CHK    = 13'h0002,
        S_DACC_M = 13'h0004,
        S_DACC_D = 13'h0008,
        S_Q_D    = 13'h0010,
        S_SQRT   = 13'h0020,
        S_VP_M   = 13'h0040,
        S_T1_D   = 13'h0080,
        S_T2_D   = 13'h0100,
        S_D1_M1  = 13'h0200,
        S_D1_M2  = 13'h0400,
        S_DC_M   = 13'h0800,
        S_FIN    = 13'h1000
    } t_sstate;

    typedef enum logic [1:0] {U_NONE, U_DIV, U_MUL, U_SQRT} t_unit;

    t_sstate r_state;
    logic    r_run;
    logic [6:0] r_cnt;
    t_unit   r_kind;

    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_quo;
    logic [31:0]    r_rem;
    logic [30:0]    r_den;
    logic [63:0]    r_ma;
    logic [63:0]    r_mb;
    logic [127:0]   r_acc;
    logic [63:0]    r_sx;
    logic [63:0]    r_sr;
    logic [63:0]    r_sbit;

    logic [31:0]    r_d;
    logic           r_neg;
    logic [63:0]    r_dacc;
    logic [63:0]    r_t1;
    logic [63:0]    r_t2;
    logic [63:0]    r_dur;
    logic [tmp_pkg::VP_W-1:0] r_vp;
    logic [60:0]    r_dist1;
    logic [61:0]    r_dist12;
    logic           r_en;

    t_unit          u_kind;
    logic [NW-1:0]  u_a;
    logic [63:0]    u_b;
    logic [6:0]     u_steps;
    logic           launch;
    logic           step;
    logic           unit_done;

    logic signed [32:0] diff;
    logic [32:0]    diff_neg;
    logic [31:0]    dist_abs;
    logic [63:0]    div_res;
    logic [31:0]    rem_sh;
    logic           div_ge;
    logic [64:0]    mul_sum;
    logic [63:0]    sq_rb;
    logic           sq_ge;
    logic [63:0]    acc_sat;

    assign diff     = {i_end_pos[31], i_end_pos} - {i_start_pos[31], i_start_pos};
    assign diff_neg = -diff;
    assign dist_abs = diff[32] ? diff_neg[31:0] : diff[31:0];

    assign div_res  = (|r_quo[NW-1:64]) ? {64{1'b1}} : r_quo[63:0];
    assign rem_sh   = {r_rem[30:0], r_num[NW-1]};
    assign div_ge   = rem_sh >= {1'b0, r_den};
    assign mul_sum  = {1'b0, r_acc[127:64]} + (r_mb[0] ? {1'b0, r_ma} : 65'd0);
    assign sq_rb    = r_sr + r_sbit;
    assign sq_ge    = r_sx >= sq_rb;
    assign acc_sat  = (|r_acc[127:64]) ? {64{1'b1}} : r_acc[63:0];

    assign launch    = (u_kind != U_NONE) && !r_run;
    assign step      = r_run && (r_cnt != 7'd0);
    assign unit_done = r_run && (r_cnt == 7'd0);

    // Operation that each step of the sequence hands to the shared iterative unit.
    always_comb begin
        u_kind  = U_NONE;
        u_a     = '0;
        u_b     = '0;
        u_steps = 7'd0;
        unique case (r_state)
            S_DACC_M: begin
                u_kind = U_MUL; u_a = NW'(i_vel_lim); u_b = 64'(i_vel_lim); u_steps = 7'd64;
            end
            S_DACC_D: begin
                u_kind = U_DIV; u_a = NW'(r_acc[63:0]); u_b = 64'(i_acc_lim);
                u_steps = 7'(NW);
            end
            S_Q_D: begin
                u_kind = U_DIV; u_a = NW'(r_d) << (2 * FRAC_BITS); u_b = 64'(i_acc_lim);
                u_steps = 7'(NW);
            end
            S_SQRT: begin
                u_kind = U_SQRT; u_b = div_res; u_steps = 7'd32;
            end
            S_VP_M, S_D1_M1: begin
                u_kind = U_MUL; u_a = NW'(r_t1); u_b = 64'(i_acc_lim); u_steps = 7'd64;
            end
            S_T1_D: begin
                u_kind = U_DIV; u_a = NW'(i_vel_lim) << FRAC_BITS; u_b = 64'(i_acc_lim);
                u_steps = 7'(NW);
            end
            S_T2_D: begin
                u_kind = U_DIV; u_a = NW'(64'(r_d) - r_dacc) << FRAC_BITS;
                u_b = 64'(i_vel_lim); u_steps = 7'(NW);
            end
            S_D1_M2: begin
                u_kind = U_MUL; u_a = NW'(acc_sat); u_b = r_t1; u_steps = 7'd64;
            end
            S_DC_M: begin
                u_kind = U_MUL; u_a = NW'(r_vp); u_b = r_t2 - r_t1; u_steps = 7'd64;
            end
            default: begin
                u_kind = U_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= 1'b0;
            r_cnt   <= 7'd0;
            r_kind  <= U_NONE;
            r_en    <= 1'b0;
        end else begin
            if (launch) begin
                r_run  <= 1'b1;
                r_kind <= u_kind;
                r_cnt  <= u_steps;
            end else if (step) begin
                r_cnt <= r_cnt - 7'd1;
            end else if (unit_done) begin
                r_run <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (i_vel_lim == '0 || i_acc_lim == '0 || dist_abs == '0) begin
                        r_en    <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DACC_M;
                    end
                end
                S_DACC_M: if (unit_done) r_state <= S_DACC_D;
                S_DACC_D: begin
                    if (unit_done) begin
                        r_state <= (64'(r_d) <= div_res) ? S_Q_D : S_T1_D;
                    end
                end
                S_Q_D:    if (unit_done) r_state <= S_SQRT;
                S_SQRT:   if (unit_done) r_state <= S_VP_M;
                S_VP_M:   if (unit_done) r_state <= S_D1_M1;
                S_T1_D:   if (unit_done) r_state <= S_T2_D;
                S_T2_D:   if (unit_done) r_state <= S_D1_M1;
                S_D1_M1:  if (unit_done) r_state <= S_D1_M2;
                S_D1_M2:  if (unit_done) r_state <= S_DC_M;
                S_DC_M:   if (unit_done) r_state <= S_FIN;
                S_FIN: begin
                    r_en    <= (r_t1 + r_t2) != 64'd0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (launch) begin
            unique case (u_kind)
                U_DIV: begin
                    r_num <= u_a;
                    r_quo <= '0;
                    r_rem <= '0;
                    r_den <= u_b[30:0];
                end
                U_MUL: begin
                    r_ma  <= u_a[63:0];
                    r_mb  <= u_b;
                    r_acc <= '0;
                end
                U_SQRT: begin
                    r_sx   <= u_b;
                    r_sr   <= '0;
                    r_sbit <= 64'h4000_0000_0000_0000;
                end
                default: begin
                end
            endcase
        end else if (step) begin
            unique case (r_kind)
                U_DIV: begin
                    r_num <= r_num << 1;
                    r_rem <= div_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                    r_quo <= {r_quo[NW-2:0], div_ge};
                end
                U_MUL: begin
                    r_acc <= {mul_sum, r_acc[63:1]};
                    r_mb  <= r_mb >> 1;
                end
                U_SQRT: begin
                    if (sq_ge) begin
                        r_sx <= r_sx - sq_rb;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end
                default: begin
                end
            endcase
        end

        if (r_state == S_CHK) begin
            r_d   <= dist_abs;
            r_neg <= diff[32];
        end
        if (r_state == S_FIN) begin
            r_dur <= r_t1 + r_t2;
        end
        if (unit_done) begin
            unique case (r_state)
                S_DACC_D: r_dacc <= div_res;
                S_SQRT: begin
                    r_t1 <= r_sr;
                    r_t2 <= r_sr;
                end
                S_VP_M:  r_vp <= r_acc[FRAC_BITS +: tmp_pkg::VP_W];
                S_T1_D:  r_t1 <= div_res;
                S_T2_D: begin
                    r_t2 <= r_t1 + div_res;
                    r_vp <= tmp_pkg::VP_W'(i_vel_lim);
                end
                S_D1_M2: r_dist1 <= tmp_pkg::cap_term(r_acc >> (2 * FRAC_BITS + 1));
                S_DC_M: begin
                    r_dist12 <= {1'b0, r_dist1} + {1'b0, tmp_pkg::cap_term(r_acc >> FRAC_BITS)};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy = r_state != S_IDLE;

    always_comb begin
        o_prof.en        = r_en;
        o_prof.neg       = r_neg;
        o_prof.t1        = r_t1;
        o_prof.t2        = r_t2;
        o_prof.dur       = r_dur;
        o_prof.vp        = r_vp;
        o_prof.dist1     = r_dist1;
        o_prof.dist12    = r_dist12;
        o_prof.start_pos = i_start_pos;
        o_prof.end_pos   = i_end_pos;
        o_prof.acc_lim   = i_acc_lim;
    end

endmodule

// File: hdl/tmp_front.sv
// Front end: takes sample times, sorts them into motion phases and queues them.
`timescale 1ns / 1ps
module tmp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic signed [31:0] i_sample_time,
    input  logic               i_hold,
    input  tmp_pkg::t_prof     i_prof,
    input  logic               i_job_take,
    output logic               o_full,
    output logic               o_job_valid,
    output tmp_pkg::t_job      o_job
);
    localparam int DEPTH = tmp_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tmp_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    tmp_pkg::t_job job;
    logic [63:0]   ut;
    logic          push_ok;
    logic          take_ok;

    assign ut = 64'(i_sample_time[30:0]);

    always_comb begin
        job.x = '0;
        priority if (!i_prof.en) begin
            job.phase = tmp_pkg::PH_END;
        end else if (i_sample_time[31] || i_sample_time == '0) begin
            job.phase = tmp_pkg::PH_BEFORE;
        end else if (ut >= i_prof.dur) begin
            job.phase = tmp_pkg::PH_END;
        end else if (ut < i_prof.t1) begin
            job.phase = tmp_pkg::PH_ACC;
            job.x     = i_sample_time[30:0];
        end else if (ut < i_prof.t2) begin
            job.phase = tmp_pkg::PH_CRU;
            job.x     = i_sample_time[30:0] - i_prof.t1[30:0];
        end else begin
            job.phase = tmp_pkg::PH_DEC;
            job.x     = i_sample_time[30:0] - i_prof.t2[30:0];
        end
    end

    assign o_full      = (r_cnt == CW'(DEPTH)) || i_hold;
    assign push_ok     = i_push && !o_full;
    assign o_job_valid = r_cnt != '0;
    assign take_ok     = i_job_take && o_job_valid;
    assign o_job       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + PW'(1);
            end
            if (take_ok) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(push_ok) - CW'(take_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= job;
        end
    end

endmodule

// File: hdl/tmp_back.sv
// Back end: multiplier pipeline that turns a queued job into position, velocity and acceleration.
`timescale 1ns / 1ps
module tmp_back #(
    parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmp_pkg::t_prof     i_prof,
    input  logic               i_job_valid,
    input  tmp_pkg::t_job      i_job,
    output logic               o_job_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_acceleration
);
    localparam int OD  = tmp_pkg::OUT_DEPTH;
    localparam int OPW = $clog2(OD);
    localparam int OCW = $clog2(OD + 1);
    localparam int VH  = tmp_pkg::VP_HALF;
    localparam int VW  = tmp_pkg::VP_W;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
    } t_result;

    logic            r1_v, r2_v, r3_v;
    tmp_pkg::t_phase r1_ph, r2_ph, r3_ph;
    logic [30:0]     r1_x;
    logic [61:0]     r1_m1;
    logic [VH+30:0]  r1_m3lo;
    logic [VW-VH+30:0] r1_m3hi;
    logic [61:0]     r2_m2lo, r2_m2hi;
    logic [60:0]     r2_lin;
    logic [61:0]     r2_velt;
    logic [60:0]     r3_sq;
    logic signed [63:0] r3_dl;
    logic signed [63:0] r3_velm;

    t_result         r_omem [OD];
    logic [OPW-1:0]  r_owp, r_orp;
    logic [OCW-1:0]  r_ocnt;

    logic [127:0]    m3_sum;
    logic [127:0]    m2_sum;
    logic [63:0]     vp64;
    logic signed [63:0] move_dist;
    logic signed [63:0] pos_move;
    logic signed [31:0] aa32;
    t_result         res;
    logic [OCW:0]    occ;
    logic            pop_ok;

    assign pop_ok = i_pop && !o_empty;
    assign occ    = (OCW + 1)'(r_ocnt) + (OCW + 1)'(r1_v) + (OCW + 1)'(r2_v) + (OCW + 1)'(r3_v);
    // Issue only with room in the result queue for everything already in flight.
    assign o_job_take = i_job_valid && (occ < (OCW + 1)'(OD) + (OCW + 1)'(pop_ok));

    assign vp64   = 64'(i_prof.vp);
    assign m3_sum = (128'(r1_m3hi) << VH) + 128'(r1_m3lo);
    assign m2_sum = (128'(r2_m2hi) << 31) + 128'(r2_m2lo);
    assign aa32   = {1'b0, i_prof.acc_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= o_job_take;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ph   <= i_job.phase;
        r1_x    <= i_job.x;
        r1_m1   <= 62'(i_prof.acc_lim) * 62'(i_job.x);
        r1_m3lo <= (VH + 31)'(i_prof.vp[VH-1:0]) * (VH + 31)'(i_job.x);
        r1_m3hi <= (VW - VH + 31)'(i_prof.vp[VW-1:VH]) * (VW - VH + 31)'(i_job.x);

        r2_ph   <= r1_ph;
        r2_m2lo <= 62'(r1_m1[30:0]) * 62'(r1_x);
        r2_m2hi <= 62'(r1_m1[61:31]) * 62'(r1_x);
        r2_lin  <= tmp_pkg::cap_term(m3_sum >> FRAC_BITS);
        r2_velt <= r1_m1 >> FRAC_BITS;

        r3_ph <= r2_ph;
        r3_sq <= tmp_pkg::cap_term(m2_sum >> (2 * FRAC_BITS + 1));
        unique case (r2_ph)
            tmp_pkg::PH_ACC: begin
                r3_dl   <= '0;
                r3_velm <= signed'(64'(r2_velt));
            end
            tmp_pkg::PH_CRU: begin
                r3_dl   <= signed'(64'(i_prof.dist1) + 64'(r2_lin));
                r3_velm <= signed'(vp64);
            end
            tmp_pkg::PH_DEC: begin
                r3_dl   <= signed'(64'(i_prof.dist12) + 64'(r2_lin));
                r3_velm <= signed'(vp64 - 64'(r2_velt));
            end
            default: begin
                r3_dl   <= '0;
                r3_velm <= '0;
            end
        endcase
    end

    always_comb begin
        unique case (r3_ph)
            tmp_pkg::PH_ACC: move_dist = signed'(64'(r3_sq));
            tmp_pkg::PH_DEC: move_dist = r3_dl - signed'(64'(r3_sq));
            default:         move_dist = r3_dl;
        endcase
        pos_move = 64'(i_prof.start_pos) + (i_prof.neg ? -move_dist : move_dist);
        unique case (r3_ph)
            tmp_pkg::PH_BEFORE: begin
                res.pos = i_prof.start_pos;
                res.vel = '0;
                res.acc = '0;
            end
            tmp_pkg::PH_ACC, tmp_pkg::PH_CRU, tmp_pkg::PH_DEC: begin
                res.pos = tmp_pkg::sat32(pos_move);
                res.vel = tmp_pkg::sat32(i_prof.neg ? -r3_velm : r3_velm);
                if (r3_ph == tmp_pkg::PH_ACC) begin
                    res.acc = i_prof.neg ? -aa32 : aa32;
                end else if (r3_ph == tmp_pkg::PH_DEC) begin
                    res.acc = i_prof.neg ? aa32 : -aa32;
                end else begin
                    res.acc = '0;
                end
            end
            default: begin
                res.pos = i_prof.end_pos;
                res.vel = '0;
                res.acc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r3_v) begin
                r_owp <= r_owp + OPW'(1);
            end
            if (pop_ok) begin
                r_orp <= r_orp + OPW'(1);
            end
            r_ocnt <= r_ocnt + OCW'(r3_v) - OCW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_v) begin
            r_omem[r_owp] <= res;
        end
    end

    assign o_empty        = r_ocnt == '0;
    assign o_position     = r_omem[r_orp].pos;
    assign o_velocity     = r_omem[r_orp].vel;
    assign o_acceleration = r_omem[r_orp].acc;

endmodule

// File: hdl/tmp_checker.sv
// Port-level checks of the trapezoidal motion profile, bound to the top level.
`timescale 1ns / 1ps
module tmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [31:0] o_position,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // A register write starts the solver, which holds off samples and writes.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_full && !o_cfg_ready)
        else $error("solver not busy after a register write");

    // While the solver runs, no sample may be taken.
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_full)
        else $error("sample side open while the profile is being derived");

    // A waiting result stays put until it is taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_position))
        else $error("waiting result changed before it was taken");

endmodule

bind trapezoidal_motion_profile tmp_checker u_tmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_full      (o_full),
    .o_empty     (o_empty),
    .i_pop       (i_pop),
    .o_position  (o_position),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
